// ----- sv/isort_pkg.sv -----
package isort_pkg;

  localparam int MAX_ITEMS_DEFAULT = 32;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               dropped;
  } result_t;

  // Per-cycle command broadcast along the cell chain.
  typedef struct packed {
    logic insert;      // compare key, shift larger entries up, drop key in gap
    logic shift_down;  // drain: every cell takes its upper neighbor
  } cell_cmd_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// ----- sv/isort_cell.sv -----
module isort_cell (
  input  logic                     clk,
  input  isort_pkg::cell_cmd_t     cmd,
  input  logic signed [31:0]       key,
  input  logic                     occupied,
  input  logic                     prev_occupied,
  input  logic                     prev_greater,
  input  logic signed [31:0]       prev_value,
  input  logic signed [31:0]       next_value,
  output logic signed [31:0]       value,
  output logic                     greater
);

  // Strictly greater only: equal entries stay below the new key.
  assign greater = occupied && (value > key);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (prev_greater) begin
        value <= prev_value;
      end else if (greater || (!occupied && prev_occupied)) begin
        value <= key;
      end
    end else if (cmd.shift_down) begin
      value <= next_value;
    end
  end

endmodule

// ----- sv/isort_ctrl.sv -----
module isort_ctrl #(
  parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEFAULT,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_last,
  input  logic                 res_ready,
  output logic                 item_ready,
  output logic                 res_valid,
  output logic                 res_last,
  output logic                 overflow,
  output logic [CW-1:0]        count,
  output isort_pkg::cell_cmd_t cmd
);

  isort_pkg::state_t state;
  isort_pkg::state_t state_next;
  logic [CW-1:0]     count_next;
  logic              overflow_next;
  logic              accept;
  logic              full;
  logic              one_left;

  assign full     = (count == CW'(MAX_ITEMS));
  assign one_left = (count == CW'(1));

  // outputs
  always_comb begin
    item_ready = 1'b0;
    res_valid  = 1'b0;
    case (state)
      isort_pkg::ST_LOAD:  item_ready = 1'b1;
      isort_pkg::ST_DRAIN: res_valid  = 1'b1;
      default: ;
    endcase
  end

  assign accept         = item_valid && item_ready;
  assign res_last       = one_left;
  assign cmd.insert     = accept && !full;
  assign cmd.shift_down = res_valid && res_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      isort_pkg::ST_LOAD: begin
        if (accept && item_last) state_next = isort_pkg::ST_DRAIN;
      end
      isort_pkg::ST_DRAIN: begin
        if (cmd.shift_down && one_left) state_next = isort_pkg::ST_LOAD;
      end
      default: state_next = isort_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    count_next    = count;
    overflow_next = overflow;
    if (cmd.insert) begin
      count_next = count + CW'(1);
    end else if (cmd.shift_down) begin
      count_next = count - CW'(1);
    end
    if (accept && full) begin
      overflow_next = 1'b1;
    end else if (cmd.shift_down && one_left) begin
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= isort_pkg::ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

endmodule

// ----- sv/insertion_sorter_top.sv -----
// Insertion sorter built as a chain of compare-and-shift cells.
//
// Input channel (item_valid / item_ready / item): one signed 32-bit value per
// beat, item.last closing the set. While loading, a beat is taken every
// cycle; each cell compares its entry against the broadcast key and either
// keeps it, takes its lower neighbor's entry, or takes the key, so one value
// is inserted per cycle.
// Output channel (res_valid / res_ready / res): once the last beat is in,
// the set drains from the bottom cell in ascending signed order, one beat
// per cycle while res_ready is high, with res.last_res on the largest
// value. Ties leave in arrival order. res.dropped is set on every beat of
// a set that offered more than MAX_ITEMS values; the extras are discarded.
// Latency: the first result appears the cycle after the last input beat.
// No input is taken while draining; the next set is loaded only once the
// last result of the current set has left.
// A stall on res_ready simply holds the chain; nothing is lost.
// Reset (rst, synchronous) empties the set and clears the drop flag; cell
// contents are not reset and are never read before being written.
module insertion_sorter_top #(
  parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  isort_pkg::item_t   item,
  output logic               res_valid,
  input  logic               res_ready,
  output isort_pkg::result_t res
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  isort_pkg::cell_cmd_t cmd;
  logic [CW-1:0]        count;
  logic                 overflow;
  logic                 res_last;

  // cell chain taps
  logic signed [31:0] cell_value [MAX_ITEMS];
  logic               cell_greater [MAX_ITEMS];
  logic               cell_occupied [MAX_ITEMS];

  isort_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .res_ready  (res_ready),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_last   (res_last),
    .overflow   (overflow),
    .count      (count),
    .cmd        (cmd)
  );

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic               prev_occupied;
      logic               prev_greater;
      logic signed [31:0] prev_value;
      logic signed [31:0] next_value;

      // Occupied cells always form a prefix of the chain.
      assign cell_occupied[i] = (CW'(i) < count);

      if (i == 0) begin : g_bottom
        assign prev_occupied = 1'b1;
        assign prev_greater  = 1'b0;
        assign prev_value    = item.value;
      end else begin : g_mid
        assign prev_occupied = cell_occupied[i-1];
        assign prev_greater  = cell_greater[i-1];
        assign prev_value    = cell_value[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_top
        assign next_value = '0;
      end else begin : g_below
        assign next_value = cell_value[i+1];
      end

      isort_cell u_cell (
        .clk           (clk),
        .cmd           (cmd),
        .key           (item.value),
        .occupied      (cell_occupied[i]),
        .prev_occupied (prev_occupied),
        .prev_greater  (prev_greater),
        .prev_value    (prev_value),
        .next_value    (next_value),
        .value         (cell_value[i]),
        .greater       (cell_greater[i])
      );
    end
  endgenerate

  // Bottom cell is always the smallest remaining entry.
  assign res.value_res = cell_value[0];
  assign res.last_res  = res_last;
  assign res.dropped   = overflow;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ITEMS   = isort_pkg::MAX_ITEMS_DEFAULT;
  localparam int RANDOM_BEATS = 160;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_TAIL  = 40;    // quiet cycles after the last result
  localparam int REPORT_MAX  = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  isort_pkg::item_t   item = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  isort_pkg::result_t res;

  insertion_sorter_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus still to be sent, and sorted results still owed by the block.
  isort_pkg::item_t   unsorted_in_q[$];
  isort_pkg::result_t sorted_out_q[$];

  // Shadow of the insertion store.
  logic signed [31:0] shadow_store [MAX_ITEMS];
  int unsigned        shadow_count = 0;
  bit                 shadow_overflow = 1'b0;

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  item_beat = 1'b0;  // beat taken at the last rising edge
  bit  res_beat = 1'b0;
  int  send_wait = 0;
  int  send_calm = 0;
  int  take_wait = 0;
  int  take_calm = 0;

  // Insert one accepted value; on a closing beat, queue the whole set in
  // ascending order and empty the shadow store.
  task automatic insert_and_flush(isort_pkg::item_t beat);
    logic signed [31:0] key;
    int                 pos;
    isort_pkg::result_t r;
    key = beat.value;
    if (shadow_count < MAX_ITEMS) begin
      pos = shadow_count;
      // only strictly larger entries move up, so ties keep arrival order
      while (pos > 0 && shadow_store[pos-1] > key) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = key;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;  // store full: value discarded
    end
    if (beat.last) begin
      for (int k = 0; k < shadow_count; k++) begin
        r.value_res = shadow_store[k];
        r.last_res  = (k == shadow_count - 1);
        r.dropped   = shadow_overflow;
        sorted_out_q.push_back(r);
      end
      shadow_count    = 0;
      shadow_overflow = 1'b0;
    end
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  // Wait before the next beat: usually a random draw, with occasional calm
  // stretches of back-to-back beats.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic push_value(logic signed [31:0] v, bit closes);
    isort_pkg::item_t b;
    b.value = v;
    b.last  = closes;
    unsorted_in_q.push_back(b);
  endtask

  // Mix of full-range words, small values that collide, and values near
  // both extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 8)) - 32'd4;
      1: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      2: return 32'h7fff_ffff - 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_set(int n);
    for (int k = 0; k < n; k++) push_value(pick_value(), k == n - 1);
  endtask

  // Input side: a beat is held until taken; a new one is presented only
  // after the previous beat went through and its wait has run out.
  always @(negedge clk) begin
    if (!rst && !(item_valid && !item_beat)) begin
      if (send_wait > 0) begin
        send_wait--;
        item_valid <= 1'b0;
      end else if (unsorted_in_q.size() != 0) begin
        item       <= unsorted_in_q.pop_front();
        item_valid <= 1'b1;
        send_wait  = draw_wait(send_calm);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Output side: after each result beat, back-pressure for a drawn stall.
  always @(negedge clk) begin
    if (!rst) begin
      if (res_beat) take_wait = draw_wait(take_calm);
      if (take_wait > 0) begin
        take_wait--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Monitor: feed accepted inputs to the shadow store and check each result
  // beat against the oldest owed result.
  always @(posedge clk) begin : monitor
    isort_pkg::result_t want;
    item_beat <= item_valid && item_ready;
    res_beat  <= res_valid && res_ready;
    if (!rst) begin
      if (item_valid && item_ready) insert_and_flush(item);
      if (res_valid && res_ready) begin
        if (sorted_out_q.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d last %0b dropped %0b",
                                 res.value_res, res.last_res, res.dropped));
        end else begin
          want = sorted_out_q.pop_front();
          if (res.value_res !== want.value_res || res.last_res !== want.last_res ||
              res.dropped !== want.dropped) begin
            note_failure($sformatf(
              "mismatch: exp value %0d last %0b dropped %0b, got value %0d last %0b dropped %0b",
              want.value_res, want.last_res, want.dropped,
              res.value_res, res.last_res, res.dropped));
          end
        end
      end
      if ((item_valid && item_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[insertion_sorter_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int n;

    // Directed sets: single extremes, sign boundaries, ties, reverse order.
    push_value(32'sh8000_0000, 1'b1);
    push_value(32'sh7fff_ffff, 1'b1);
    push_value(0, 1'b0);
    push_value(-1, 1'b0);
    push_value(32'sh7fff_ffff, 1'b0);
    push_value(32'sh8000_0000, 1'b0);
    push_value(1, 1'b1);
    push_value(7, 1'b0);
    push_value(7, 1'b0);
    push_value(-7, 1'b0);
    push_value(7, 1'b0);
    push_value(-7, 1'b1);
    push_value(100, 1'b0);
    push_value(50, 1'b0);
    push_value(0, 1'b0);
    push_value(-50, 1'b0);
    push_value(-100, 1'b1);
    push_value(-3, 1'b0);
    push_value(-2, 1'b0);
    push_value(-1, 1'b1);

    // Overflowed set closed by a discarded value, then an exactly full set.
    queue_random_set(MAX_ITEMS + 2);
    queue_random_set(MAX_ITEMS);
    sent = unsorted_in_q.size();
    while (sent < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(MAX_ITEMS - 1, MAX_ITEMS + 3);
      else n = $urandom_range(1, 10);
      queue_random_set(n);
      sent += n;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (unsorted_in_q.size() != 0 || item_valid) @(posedge clk);
    while (sorted_out_q.size() != 0) @(posedge clk);
    // catch any stray beats after the last owed result
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0) begin
      $display("[insertion_sorter_top] OK");
    end else begin
      $display("[insertion_sorter_top] ERROR");
    end
    $finish;
  end

endmodule
